// File: hw/rtl/heightfield_height_query_macros.svh
// Assertion helpers used by hhq_ctrl.sv.
`ifndef HEIGHTFIELD_HEIGHT_QUERY_MACROS_SVH
`define HEIGHTFIELD_HEIGHT_QUERY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HHQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/hhq_pkg.sv
package hhq_pkg;

   localparam int MAX_DIM_DEF   = 256;
   localparam int FRAC_BITS_DEF = 8;

   localparam int CFG_W      = 9;
   localparam int POS_W      = 16;
   localparam int INDEX_W    = 16;
   localparam int LEVEL_W    = 8;
   localparam int HEIGHT_W   = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_IDX_WIDTH = 1'b0;
   localparam logic CSR_IDX_DEPTH = 1'b1;

   localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] depth;
   } hhq_cfg_type;

endpackage

// File: hw/rtl/hhq_ram.sv
module hhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/hhq_csr.sv
module hhq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hhq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hhq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hhq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output hhq_pkg::hhq_cfg_type                cfg
);

   import hhq_pkg::*;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] depth_ff, depth_in;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in = width_ff;
      depth_in = depth_ff;
      if (wr_hit) begin
         case (csr_paddr[2])
            CSR_IDX_WIDTH: width_in = csr_pwdata[CFG_W-1:0];
            CSR_IDX_DEPTH: depth_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_RESET;
         depth_ff <= DIM_RESET;
      end else begin
         width_ff <= width_in;
         depth_ff <= depth_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_WIDTH: csr_prdata = CSR_DATA_W'(width_ff);
         CSR_IDX_DEPTH: csr_prdata = CSR_DATA_W'(depth_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.width = width_ff;
   assign cfg.depth = depth_ff;

endmodule

// File: hw/rtl/hhq_ctrl.sv
`include "heightfield_height_query_macros.svh"

module hhq_ctrl #(
   parameter int MAX_DIM   = hhq_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = hhq_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   op,
   input  logic [hhq_pkg::INDEX_W-1:0]            sample_index,
   input  logic [hhq_pkg::LEVEL_W-1:0]            sample_level,
   input  logic [hhq_pkg::POS_W-1:0]              pos_x,
   input  logic [hhq_pkg::POS_W-1:0]              pos_z,
   input  hhq_pkg::hhq_cfg_type                   cfg,
   output logic                                   ram_wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     ram_wr_addr,
   output logic [hhq_pkg::LEVEL_W-1:0]            ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     ram_rd_addr,
   input  logic [hhq_pkg::LEVEL_W-1:0]            ram_rd_data,
   output logic                                   rsp_valid,
   output logic [hhq_pkg::HEIGHT_W-1:0]           height,
   output logic                                   out_of_range
);

   import hhq_pkg::*;

   localparam int STORE_SIZE = MAX_DIM * MAX_DIM;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int CW         = (DIM_W > CFG_W) ? DIM_W : CFG_W;
   localparam int COL_W      = (POS_W - FRAC_BITS > 0) ? POS_W - FRAC_BITS : 1;
   localparam int EW         = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
   localparam int FW         = FRAC_BITS + 1;
   localparam int ONE_FX     = 1 << FRAC_BITS;
   localparam int ACC_W      = LEVEL_W + FRAC_BITS;
   localparam int SUM_W      = ACC_W + 9;
   localparam int SH_R       = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
   localparam int SH_L       = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
   localparam int RND        = (FRAC_BITS > 8) ? (1 << SH_R) / 2 : 0;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam logic [1:0] C_RIGHT = 2'd0;
   localparam logic [1:0] C_UP    = 2'd1;
   localparam logic [1:0] C_THIRD = 2'd2;

   logic [2:0]           state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [COL_W-1:0]     row_ff, row_in;
   logic [FRAC_BITS-1:0] fx_ff, fx_in;
   logic [FRAC_BITS-1:0] fz_ff, fz_in;
   logic [DIM_W-1:0]     w_ff, w_in;
   logic [DIM_W-1:0]     d_ff, d_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic                 upper_ff, upper_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HEIGHT_W-1:0]  height_ff, height_in;
   logic                 oor_ff, oor_in;

   logic                 accept;
   logic                 outside;
   logic [CW-1:0]        wc, dc;
   logic [FW-1:0]        fxz;
   logic [1:0]           data_corner;
   logic [FW-1:0]        weight;
   logic [SUM_W-1:0]     rounded;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign ram_wr_en   = accept && (op == OP_WRITE) && (32'(sample_index) < STORE_SIZE);
   assign ram_wr_addr = ADDR_W'(sample_index);
   assign ram_wr_data = sample_level;

   always_comb begin
      wc = CW'(cfg.width);
      dc = CW'(cfg.depth);
      if (wc < CW'(2)) begin
         wc = CW'(2);
      end else if (wc > CW'(MAX_DIM)) begin
         wc = CW'(MAX_DIM);
      end
      if (dc < CW'(2)) begin
         dc = CW'(2);
      end else if (dc > CW'(MAX_DIM)) begin
         dc = CW'(MAX_DIM);
      end
   end

   assign outside = (EW'(col_ff) + EW'(1) >= EW'(w_ff)) ||
                    (EW'(row_ff) + EW'(1) >= EW'(d_ff));
   assign fxz     = FW'(fx_ff) + FW'(fz_ff);

   always_comb begin
      ram_rd_en   = (state_ff == S_READ);
      ram_rd_addr = base_ff;
      case (cnt_ff)
         C_RIGHT: ram_rd_addr = base_ff + ADDR_W'(1);
         C_UP:    ram_rd_addr = base_ff + ADDR_W'(w_ff);
         C_THIRD: ram_rd_addr = upper_ff ? base_ff + ADDR_W'(w_ff) + ADDR_W'(1) : base_ff;
         default: ram_rd_addr = base_ff;
      endcase
   end

   always_comb begin
      data_corner = (state_ff == S_LAST) ? C_THIRD : cnt_ff - 2'd1;
      case (data_corner)
         C_RIGHT: weight = upper_ff ? FW'(ONE_FX) - FW'(fz_ff) : FW'(fx_ff);
         C_UP:    weight = upper_ff ? FW'(ONE_FX) - FW'(fx_ff) : FW'(fz_ff);
         C_THIRD: weight = upper_ff ? fxz - FW'(ONE_FX) : FW'(ONE_FX) - fxz;
         default: weight = '0;
      endcase
   end

   assign rounded = ((SUM_W'(acc_ff) + SUM_W'(RND)) >> SH_R) << SH_L;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      fx_in        = fx_ff;
      fz_in        = fz_ff;
      w_in         = w_ff;
      d_in         = d_ff;
      base_in      = base_ff;
      upper_in     = upper_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      height_in    = height_ff;
      oor_in       = oor_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (op == OP_QUERY)) begin
               col_in   = COL_W'(pos_x >> FRAC_BITS);
               row_in   = COL_W'(pos_z >> FRAC_BITS);
               fx_in    = FRAC_BITS'(pos_x);
               fz_in    = FRAC_BITS'(pos_z);
               w_in     = DIM_W'(wc);
               d_in     = DIM_W'(dc);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            base_in  = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(w_ff)) + ADDR_W'(col_ff);
            upper_in = (fxz > FW'(ONE_FX));
            cnt_in   = C_RIGHT;
            acc_in   = '0;
            if (outside) begin
               rsp_valid_in = 1'b1;
               height_in    = '0;
               oor_in       = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (cnt_ff != C_RIGHT) begin
               acc_in = acc_ff + ACC_W'(ACC_W'(weight) * ACC_W'(ram_rd_data));
            end
            if (cnt_ff == C_THIRD) begin
               state_in = S_LAST;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         S_LAST: begin
            acc_in   = acc_ff + ACC_W'(ACC_W'(weight) * ACC_W'(ram_rd_data));
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            height_in    = HEIGHT_W'(rounded);
            oor_in       = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= C_RIGHT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      row_ff    <= row_in;
      fx_ff     <= fx_in;
      fz_ff     <= fz_in;
      w_ff      <= w_in;
      d_ff      <= d_in;
      base_ff   <= base_in;
      upper_ff  <= upper_in;
      acc_ff    <= acc_in;
      height_ff <= height_in;
      oor_ff    <= oor_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign height       = height_ff;
   assign out_of_range = oor_ff;

   `HHQ_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `HHQ_ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid_ff && oor_ff, height_ff == '0, "out-of-range result with nonzero height")
   `HHQ_ASSERT_NEXT(a_write_no_busy, clock, reset, accept && (op == OP_WRITE), !busy && !rsp_valid_ff, "write transaction stalled or produced a result")
   `HHQ_ASSERT_NEXT(a_query_busy, clock, reset, accept && (op == OP_QUERY), busy, "query transaction not taken up")

endmodule

// File: hw/rtl/heightfield_height_query.sv
// Write transaction: stored at the accepting edge, busy stays low, next item the cycle after.
// Query transaction: busy rises after accept; out of range, S_CHECK registers the result strobe;
// else the strobe follows S_READ with three serial corner reads from the single height RAM,
// S_LAST with the last accumulate and S_OUT with the output register; busy falls with the strobe.
// The receiver cannot stall: each result is on rsp_ for exactly one cycle.
// Synchronous reset clears control and sets the width and depth CSRs to 256; RAM is not cleared.
module heightfield_height_query #(
   parameter int MAX_DIM   = hhq_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = hhq_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [hhq_pkg::INDEX_W-1:0]      req_sample_index,
   input  logic [hhq_pkg::LEVEL_W-1:0]      req_sample_level,
   input  logic [hhq_pkg::POS_W-1:0]        req_pos_x,
   input  logic [hhq_pkg::POS_W-1:0]        req_pos_z,
   output logic                             rsp_valid,
   output logic [hhq_pkg::HEIGHT_W-1:0]     rsp_height,
   output logic                             rsp_out_of_range,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hhq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hhq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hhq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   import hhq_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   hhq_cfg_type         cfg;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [LEVEL_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [LEVEL_W-1:0]  ram_rd_data;

   hhq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hhq_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (MAX_DIM * MAX_DIM)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hhq_ctrl #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .op           (req_op),
      .sample_index (req_sample_index),
      .sample_level (req_sample_level),
      .pos_x        (req_pos_x),
      .pos_z        (req_pos_z),
      .cfg          (cfg),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_valid    (rsp_valid),
      .height       (rsp_height),
      .out_of_range (rsp_out_of_range)
   );

endmodule
